/* sv/rdq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rdq_pkg;

  // ring geometry
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  // payload widths fixed by the interface
  localparam int unsigned FuncW = 3;
  localparam int unsigned ValW  = 10;

  typedef enum logic [FuncW-1:0] {
    FUNC_APPEND  = 3'd0,
    FUNC_REVERSE = 3'd1,
    FUNC_DISCARD = 3'd2,
    FUNC_TAKE    = 3'd3,
    FUNC_CLEAR   = 3'd4
  } func_e;

  // storage access issued by the controller for one beat
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ValW-1:0]  wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // status of the queue after one beat
  typedef struct packed {
    logic            take;
    logic            error;
    logic            empty;
    logic [CntW-1:0] count;
  } res_t;

  function automatic logic [AddrW-1:0] wrap_inc(input logic [AddrW-1:0] idx);
    logic [AddrW-1:0] r;
    if (idx == AddrW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + AddrW'(1);
    end
    return r;
  endfunction

  function automatic logic [AddrW-1:0] wrap_dec(input logic [AddrW-1:0] idx);
    logic [AddrW-1:0] r;
    if (idx == '0) begin
      r = AddrW'(DEPTH - 1);
    end else begin
      r = idx - AddrW'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/rdq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rdq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/rdq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module rdq_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic [rdq_pkg::FuncW-1:0]    func_i,
  input  wire logic [rdq_pkg::ValW-1:0]     value_i,
  output rdq_pkg::mem_req_t                 mem_req_o,
  output rdq_pkg::res_t                     res_o
);

  logic [rdq_pkg::AddrW-1:0] front_q, front_d;
  logic [rdq_pkg::AddrW-1:0] back_q, back_d;
  logic [rdq_pkg::CntW-1:0]  held_q, held_d;
  logic                      rev_q, rev_d;
  logic                      err_q, err_d;
  rdq_pkg::mem_req_t         req;

  // next pointer state and storage access for the incoming beat
  always_comb begin
    front_d   = front_q;
    back_d    = back_q;
    held_d    = held_q;
    rev_d     = rev_q;
    err_d     = err_q;
    req       = '0;
    req.wdata = value_i;

    if (func_i == rdq_pkg::FUNC_CLEAR) begin
      front_d = '0;
      back_d  = '0;
      held_d  = '0;
      rev_d   = 1'b0;
      err_d   = 1'b0;
    end else if (!err_q) begin
      unique case (func_i) inside
        rdq_pkg::FUNC_APPEND: begin
          if (held_q == rdq_pkg::CntW'(rdq_pkg::DEPTH)) begin
            err_d = 1'b1;
          end else if (rev_q) begin
            // reversed: grow below the physical front
            front_d   = rdq_pkg::wrap_dec(front_q);
            req.we    = 1'b1;
            req.waddr = front_d;
            held_d    = held_q + rdq_pkg::CntW'(1);
          end else begin
            req.we    = 1'b1;
            req.waddr = back_q;
            back_d    = rdq_pkg::wrap_inc(back_q);
            held_d    = held_q + rdq_pkg::CntW'(1);
          end
        end
        rdq_pkg::FUNC_REVERSE: begin
          rev_d = ~rev_q;
        end
        rdq_pkg::FUNC_DISCARD, rdq_pkg::FUNC_TAKE: begin
          if (held_q == '0) begin
            err_d = 1'b1;
          end else begin
            req.re = (func_i == rdq_pkg::FUNC_TAKE);
            if (rev_q) begin
              back_d    = rdq_pkg::wrap_dec(back_q);
              req.raddr = back_d;
            end else begin
              req.raddr = front_q;
              front_d   = rdq_pkg::wrap_inc(front_q);
            end
            held_d = held_q - rdq_pkg::CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      held_q  <= '0;
      rev_q   <= 1'b0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      front_q <= front_d;
      back_q  <= back_d;
      held_q  <= held_d;
      rev_q   <= rev_d;
      err_q   <= err_d;
    end
  end

  // storage access only on an accepted beat
  always_comb begin
    mem_req_o    = req;
    mem_req_o.we = req.we & accept_i;
    mem_req_o.re = req.re & accept_i;
  end

  assign res_o.take  = req.re;
  assign res_o.error = err_d;
  assign res_o.empty = (held_d == '0);
  assign res_o.count = held_d;

endmodule

`default_nettype wire

/* sv/reversible_deque.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of rdq_pkg::DEPTH ten-bit entries in a ring buffer with a
// direction flag. Every input beat produces exactly one result beat, in the cycle after
// acceptance; the block takes one operation per cycle as long as the result side keeps
// up, since the next beat is accepted in the same cycle the pending result is taken.
// The result delay is the registered read of the entry store, which a take reads.
// A discard or take on an empty queue, or an append to a full one, sets a sticky error;
// only clear or reset recovers from it. Storage is not initialized after reset and
// needs no clearing pass: only appended entries are ever read.
module reversible_deque (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [rdq_pkg::FuncW-1:0]    func_i,
  input  wire logic [rdq_pkg::ValW-1:0]     value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [rdq_pkg::ValW-1:0]     taken_value_o,
  output logic                              error_o,
  output logic                              empty_res_o,
  output logic      [rdq_pkg::CntW-1:0]     count_o
);

  logic              accept;
  logic              out_valid_q;
  rdq_pkg::res_t     res_d;
  rdq_pkg::res_t     res_q;
  rdq_pkg::mem_req_t mem_req;
  logic [rdq_pkg::ValW-1:0] rdata;

  // a new beat enters while the pending result leaves
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  rdq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .func_i    (func_i),
    .value_i   (value_i),
    .mem_req_o (mem_req),
    .res_o     (res_d)
  );

  rdq_ram #(
    .Width (rdq_pkg::ValW),
    .Depth (rdq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  // read data stays put until the next take is accepted
  assign out_valid_o   = out_valid_q;
  assign taken_value_o = res_q.take ? rdata : '0;
  assign error_o       = res_q.error;
  assign empty_res_o   = res_q.empty;
  assign count_o       = res_q.count;

endmodule

`default_nettype wire

/* sv/reversible_deque_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module reversible_deque_chk (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic [rdq_pkg::FuncW-1:0]    func_i,
  input wire logic [rdq_pkg::ValW-1:0]     value_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [rdq_pkg::ValW-1:0]     taken_value_o,
  input wire logic                         error_o,
  input wire logic                         empty_res_o,
  input wire logic [rdq_pkg::CntW-1:0]     count_o
);

  // every accepted beat shows a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("no result after accepted beat");

  // empty flag agrees with the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (empty_res_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

  // fill level never passes capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= rdq_pkg::CntW'(rdq_pkg::DEPTH)))
    else $error("count beyond capacity");

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(taken_value_o)
      && $stable(error_o) && $stable(count_o)))
    else $error("stalled result changed");

endmodule

bind reversible_deque reversible_deque_chk u_chk (.*);

`default_nettype wire
